/* sv/sdp_pkg.sv */
// sdp_pkg: shared widths, operation and status codes and sequencer states
// for the sparse dot product block; no dependencies
package sdp_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int OP_W  = 2;
  localparam int IDX_W = 16;
  localparam int VAL_W = 16;
  localparam int RES_W = 40;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_DOT    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_ORDER = 2'd2;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_FLUSH,
    S_FIN
  } state_t;

endpackage

/* sv/sdp_in_if.sv */
// sdp_in_if: input channel of the sparse dot product block, one element
// load, compute or clear request per word; uses sdp_pkg
interface sdp_in_if;
  logic                              valid;
  logic                              ready;
  logic [sdp_pkg::OP_W-1:0]          operation;
  logic [sdp_pkg::IDX_W-1:0]         feature_index;
  logic signed [sdp_pkg::VAL_W-1:0]  feature_value;

  modport source (output valid, output operation, output feature_index,
                  output feature_value, input ready);
  modport sink (input valid, input operation, input feature_index,
                input feature_value, output ready);
endinterface

/* sv/sdp_out_if.sv */
// sdp_out_if: result channel of the sparse dot product block, one word per
// accepted request; uses sdp_pkg
interface sdp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdp_pkg::RES_W-1:0]  dot_result;
  logic [sdp_pkg::ST_W-1:0]          status;

  modport source (output valid, output dot_result, output status, input ready);
  modport sink (input valid, input dot_result, input status, output ready);
endinterface

/* sv/sparse_dot_product_merge.sv */
// sparse_dot_product_merge: two sparse vector stores and a two-pointer merge
// that multiply-accumulates matching indices; uses sdp_pkg, sdp_in_if, sdp_out_if
//
//  channel   modport  dir  payload                                   role
//  items     sink     in   operation, feature_index, feature_value   load / dot / clear
//  results   source   out  dot_result (Q40.0), status                one word per item
//
//  load and clear write their result word straight into the output register
//  dot runs n merge steps in S_MERGE (at most a_count + b_count - 1), then
//  S_FLUSH and S_FIN, with one registered read port per store and one shared
//  multiply-accumulate; dot with either store empty goes straight to S_FIN
//  items.ready is low while a dot runs and while a result word is stalled
//  synchronous reset empties both stores; the store memories are not cleared
module sparse_dot_product_merge #(
  parameter int MAX_ENTRIES = sdp_pkg::MAX_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  sdp_in_if.sink     items,
  sdp_out_if.source  results
);

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int EW     = sdp_pkg::IDX_W + sdp_pkg::VAL_W;
  localparam int PROD_W = 2 * sdp_pkg::VAL_W;
  localparam int ACC_W  = PROD_W + CW;
  localparam int SAT_W  = (ACC_W > sdp_pkg::RES_W) ? ACC_W : sdp_pkg::RES_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(sdp_pkg::RES_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(sdp_pkg::RES_MIN);

  sdp_pkg::state_t state, state_next;

  // element stores: index in the upper half, value in the lower half
  logic [EW-1:0] mem_a [MAX_ENTRIES];
  logic [EW-1:0] mem_b [MAX_ENTRIES];
  logic [EW-1:0] rd_a, rd_b;
  logic [AW-1:0] raddr_a, raddr_b;

  logic [CW-1:0] a_count, b_count;
  logic [sdp_pkg::IDX_W-1:0] a_last, b_last;

  logic [CW-1:0] p, q, p_next, q_next;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_hit;
  logic signed [ACC_W-1:0]  acc;

  logic                                 out_valid;
  logic signed [sdp_pkg::RES_W-1:0]     dot_q;
  logic [sdp_pkg::ST_W-1:0]             status_q;

  logic accept;
  logic is_load, is_dot, is_clear;
  logic [CW-1:0] sel_count;
  logic [sdp_pkg::IDX_W-1:0] sel_last;
  logic [sdp_pkg::ST_W-1:0] load_status;
  logic wr_a, wr_b;
  logic fin;

  logic [sdp_pkg::IDX_W-1:0] ia, ib;
  logic signed [sdp_pkg::VAL_W-1:0] va, vb;
  logic match, merge_end;
  logic signed [SAT_W-1:0] acc_w;
  logic signed [sdp_pkg::RES_W-1:0] sat;

  // request decode
  assign accept   = items.valid && items.ready;
  assign is_load  = (items.operation == sdp_pkg::OP_LOAD_A) ||
                    (items.operation == sdp_pkg::OP_LOAD_B);
  assign is_dot   = (items.operation == sdp_pkg::OP_DOT);
  assign is_clear = (items.operation == sdp_pkg::OP_CLEAR);

  // the order check uses the last index kept in a register, so a load never
  // needs a memory read
  always_comb begin
    if (items.operation == sdp_pkg::OP_LOAD_B) begin
      sel_count = b_count;
      sel_last  = b_last;
    end else begin
      sel_count = a_count;
      sel_last  = a_last;
    end
    if (sel_count == COUNT_MAX) begin
      load_status = sdp_pkg::ST_FULL;
    end else if ((sel_count != '0) && (items.feature_index <= sel_last)) begin
      load_status = sdp_pkg::ST_ORDER;
    end else begin
      load_status = sdp_pkg::ST_OK;
    end
  end

  assign wr_a = accept && (items.operation == sdp_pkg::OP_LOAD_A) &&
                (load_status == sdp_pkg::ST_OK);
  assign wr_b = accept && (items.operation == sdp_pkg::OP_LOAD_B) &&
                (load_status == sdp_pkg::ST_OK);

  // merge step on the element pair read last cycle
  assign ia = rd_a[EW-1:sdp_pkg::VAL_W];
  assign ib = rd_b[EW-1:sdp_pkg::VAL_W];
  assign va = signed'(rd_a[sdp_pkg::VAL_W-1:0]);
  assign vb = signed'(rd_b[sdp_pkg::VAL_W-1:0]);
  assign match = (ia == ib);

  always_comb begin
    p_next = p;
    q_next = q;
    if (match || (ia < ib)) begin
      p_next = p + CW'(1);
    end
    if (match || (ia > ib)) begin
      q_next = q + CW'(1);
    end
  end

  assign merge_end = (p_next == a_count) || (q_next == b_count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdp_pkg::S_IDLE: begin
        if (accept && is_dot) begin
          if ((a_count == '0) || (b_count == '0)) begin
            state_next = sdp_pkg::S_FIN;
          end else begin
            state_next = sdp_pkg::S_MERGE;
          end
        end
      end
      sdp_pkg::S_MERGE: begin
        if (merge_end) begin
          state_next = sdp_pkg::S_FLUSH;
        end
      end
      sdp_pkg::S_FLUSH: state_next = sdp_pkg::S_FIN;
      sdp_pkg::S_FIN:   state_next = sdp_pkg::S_IDLE;
      default:          state_next = sdp_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: read addresses run one step ahead of the compare
  always_comb begin
    items.ready = 1'b0;
    raddr_a     = '0;
    raddr_b     = '0;
    fin         = 1'b0;
    case (state)
      sdp_pkg::S_IDLE: begin
        items.ready = !out_valid || results.ready;
      end
      sdp_pkg::S_MERGE: begin
        raddr_a = p_next[AW-1:0];
        raddr_b = q_next[AW-1:0];
      end
      sdp_pkg::S_FLUSH: begin
      end
      sdp_pkg::S_FIN: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[a_count[AW-1:0]] <= {items.feature_index, items.feature_value};
    end
    rd_a <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[b_count[AW-1:0]] <= {items.feature_index, items.feature_value};
    end
    rd_b <= mem_b[raddr_b];
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      a_count <= '0;
      b_count <= '0;
    end else if (accept && is_clear) begin
      a_count <= '0;
      b_count <= '0;
    end else begin
      if (wr_a) begin
        a_count <= a_count + CW'(1);
      end
      if (wr_b) begin
        b_count <= b_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_last <= items.feature_index;
    end
    if (wr_b) begin
      b_last <= items.feature_index;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
      q <= '0;
    end else if (accept && is_dot) begin
      p <= '0;
      q <= '0;
    end else if (state == sdp_pkg::S_MERGE) begin
      p <= p_next;
      q <= q_next;
    end
  end

  // shared multiply-accumulate: product registered, added on the next cycle
  always_ff @(posedge clk) begin
    prod <= va * vb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_hit <= 1'b0;
      acc      <= '0;
    end else begin
      prod_hit <= (state == sdp_pkg::S_MERGE) && match;
      if (accept && is_dot) begin
        acc <= '0;
      end else if (prod_hit) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // saturate to the 40-bit result range
  assign acc_w = SAT_W'(acc);
  always_comb begin
    if (acc_w > SAT_HI) begin
      sat = sdp_pkg::RES_MAX;
    end else if (acc_w < SAT_LO) begin
      sat = sdp_pkg::RES_MIN;
    end else begin
      sat = acc_w[sdp_pkg::RES_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (is_load || is_clear)) || fin) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      dot_q    <= '0;
      status_q <= load_status;
    end else if (accept && is_clear) begin
      dot_q    <= '0;
      status_q <= sdp_pkg::ST_OK;
    end else if (fin) begin
      dot_q    <= sat;
      status_q <= sdp_pkg::ST_OK;
    end
  end

  assign results.valid      = out_valid;
  assign results.dot_result = dot_q;
  assign results.status     = status_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= COUNT_MAX) && (b_count <= COUNT_MAX))
    else $error("store count above capacity");

  a_merge_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sdp_pkg::S_MERGE) |-> ((p < a_count) && (q < b_count)))
    else $error("merge pointer beyond fill count");

  a_empty_dot: assert property (@(posedge clk) disable iff (rst)
    (accept && is_dot && ((a_count == '0) || (b_count == '0)))
      |=> (state == sdp_pkg::S_FIN))
    else $error("dot on empty store did not finish at once");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == sdp_pkg::S_FIN) |-> !out_valid)
    else $error("dot result would overwrite a pending word");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && is_clear) |=> ((a_count == '0) && (b_count == '0) &&
      out_valid && (status_q == sdp_pkg::ST_OK)))
    else $error("clear did not empty the stores");
`endif

endmodule
